/* rtl/dequ_pkg.sv */
// Shared constants, action and status codes, and the memory request type
// for the double-ended queue. No dependencies.
`default_nettype none

package dequ_pkg;

   localparam int Depth       = 64;
   localparam int AddrWidth   = $clog2(Depth);
   localparam int SumWidth    = AddrWidth + 2;
   localparam int CountWidth  = 7;
   localparam int WordWidth   = 32;
   localparam int ActionWidth = 3;
   localparam int StatusWidth = 2;

   localparam logic [ActionWidth-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ActionWidth-1:0] ACT_POP_BACK   = 3'd1;
   localparam logic [ActionWidth-1:0] ACT_PUSH_BACK  = 3'd2;
   localparam logic [ActionWidth-1:0] ACT_POP_FRONT  = 3'd3;
   localparam logic [ActionWidth-1:0] ACT_REVERSE    = 3'd4;

   localparam logic [StatusWidth-1:0] STATUS_OK    = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic                 wr_en;
      logic                 rd_en;
      logic [AddrWidth-1:0] addr;
      logic [WordWidth-1:0] wr_data;
   } mem_req_type;

endpackage

`default_nettype wire

/* rtl/double_ended_queue_unit.sv */
// Top level of the double-ended queue: control and result register plus the word store.
// Depends on dequ_pkg, dequ_ram and dequ_ctrl.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_action, req_push_value
//   rsp       out        rsp_valid/rsp_ready  rsp_pop_value, rsp_status, rsp_fill_count
//
// For a push, a reverse, an idle code or a failed pop, the result shows the next cycle.
// A successful pop passes its word through the store's registered read port and then the result register.
// A new request is taken while the previous result is being accepted in the same cycle.
// Reset clears head, count and direction at once; the store itself is never cleared.
// A stalled result blocks new requests until it is taken.
`default_nettype none

module double_ended_queue_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [dequ_pkg::ActionWidth-1:0]      req_action,
   input  wire logic signed [dequ_pkg::WordWidth-1:0] req_push_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [dequ_pkg::WordWidth-1:0]      rsp_pop_value,
   output logic [dequ_pkg::StatusWidth-1:0]           rsp_status,
   output logic [dequ_pkg::CountWidth-1:0]            rsp_fill_count
);

   dequ_pkg::mem_req_type           mem_req;
   logic [dequ_pkg::WordWidth-1:0]  mem_rd_data;

   dequ_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count),
      .mem_req        (mem_req),
      .mem_rd_data    (mem_rd_data)
   );

   dequ_ram #(
      .Width (dequ_pkg::WordWidth),
      .Depth (dequ_pkg::Depth)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .rd_en   (mem_req.rd_en),
      .addr    (mem_req.addr),
      .wr_data (mem_req.wr_data),
      .rd_data (mem_rd_data)
   );

   // a store read yields an ok result once the word has landed in the result register
   assert property (@(posedge clock) disable iff (reset)
      mem_req.rd_en |=> ##1 (rsp_valid && rsp_status == dequ_pkg::STATUS_OK))
      else $error("pop read did not produce a result");

   assert property (@(posedge clock) disable iff (reset)
      !(mem_req.rd_en && mem_req.wr_en))
      else $error("store read and write in the same cycle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dequ_pkg::STATUS_OK |-> rsp_pop_value == '0)
      else $error("failed request returned a nonzero word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fill_count <= dequ_pkg::CountWidth'(dequ_pkg::Depth))
      else $error("fill count beyond depth");

endmodule

`default_nettype wire

/* rtl/dequ_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// Standalone; no package dependencies.
`default_nettype none

module dequ_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] store_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/dequ_ctrl.sv */
// Ring pointer control, request decode and result register for the queue.
// Depends on dequ_pkg; drives the word store through a mem_req_type request.
`default_nettype none

module dequ_ctrl (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [dequ_pkg::ActionWidth-1:0]      req_action,
   input  wire logic signed [dequ_pkg::WordWidth-1:0] req_push_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [dequ_pkg::WordWidth-1:0]      rsp_pop_value,
   output logic [dequ_pkg::StatusWidth-1:0]           rsp_status,
   output logic [dequ_pkg::CountWidth-1:0]            rsp_fill_count,
   output dequ_pkg::mem_req_type                      mem_req,
   input  wire logic [dequ_pkg::WordWidth-1:0]        mem_rd_data
);

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_READ = 1'b1;

   logic                               state_ff, state_in;
   logic [dequ_pkg::AddrWidth-1:0]     head_ff, head_in;
   logic [dequ_pkg::CountWidth-1:0]    count_ff, count_in;
   logic                               flip_ff, flip_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [dequ_pkg::WordWidth-1:0]     rsp_value_ff, rsp_value_in;
   logic [dequ_pkg::StatusWidth-1:0]   rsp_status_ff, rsp_status_in;
   logic [dequ_pkg::CountWidth-1:0]    rsp_count_ff, rsp_count_in;

   logic                               accept;
   logic                               is_full;
   logic                               is_empty;
   logic                               at_head;
   logic [dequ_pkg::SumWidth-1:0]      sum;
   logic [dequ_pkg::SumWidth-1:0]      sum_m1;
   logic [dequ_pkg::AddrWidth-1:0]     tail_pos;
   logic [dequ_pkg::AddrWidth-1:0]     last_pos;
   logic [dequ_pkg::AddrWidth-1:0]     head_dec;
   logic [dequ_pkg::AddrWidth-1:0]     head_inc;

   assign req_ready = (state_ff == STATE_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign is_full  = (count_ff >= dequ_pkg::CountWidth'(dequ_pkg::Depth));
   assign is_empty = (count_ff == '0);

   // Ring positions: head + count stays below twice the depth, one subtract wraps it.
   assign sum    = dequ_pkg::SumWidth'(head_ff) + dequ_pkg::SumWidth'(count_ff);
   assign sum_m1 = sum - dequ_pkg::SumWidth'(1);
   assign tail_pos = (sum >= dequ_pkg::SumWidth'(dequ_pkg::Depth))
      ? dequ_pkg::AddrWidth'(sum - dequ_pkg::SumWidth'(dequ_pkg::Depth))
      : dequ_pkg::AddrWidth'(sum);
   assign last_pos = (sum_m1 >= dequ_pkg::SumWidth'(dequ_pkg::Depth))
      ? dequ_pkg::AddrWidth'(sum_m1 - dequ_pkg::SumWidth'(dequ_pkg::Depth))
      : dequ_pkg::AddrWidth'(sum_m1);
   assign head_dec = (head_ff == '0)
      ? dequ_pkg::AddrWidth'(dequ_pkg::Depth - 1)
      : head_ff - dequ_pkg::AddrWidth'(1);
   assign head_inc = (head_ff == dequ_pkg::AddrWidth'(dequ_pkg::Depth - 1))
      ? '0
      : head_ff + dequ_pkg::AddrWidth'(1);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      flip_in       = flip_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      mem_req       = '0;
      at_head       = 1'b0;

      if (state_ff == STATE_READ) begin
         // read data lands now; count already holds the post-pop value
         state_in      = STATE_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_value_in  = mem_rd_data;
         rsp_status_in = dequ_pkg::STATUS_OK;
         rsp_count_in  = count_ff;
      end else if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = dequ_pkg::STATUS_OK;
         rsp_count_in  = count_ff;
         unique case (req_action)
            dequ_pkg::ACT_PUSH_FRONT, dequ_pkg::ACT_PUSH_BACK: begin
               if (is_full) begin
                  rsp_status_in = dequ_pkg::STATUS_FULL;
               end else begin
                  at_head = (req_action == dequ_pkg::ACT_PUSH_FRONT) != flip_ff;
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_data = req_push_value;
                  if (at_head) begin
                     mem_req.addr = head_dec;
                     head_in      = head_dec;
                  end else begin
                     mem_req.addr = tail_pos;
                  end
                  count_in     = count_ff + dequ_pkg::CountWidth'(1);
                  rsp_count_in = count_in;
               end
            end
            dequ_pkg::ACT_POP_FRONT, dequ_pkg::ACT_POP_BACK: begin
               if (is_empty) begin
                  rsp_status_in = dequ_pkg::STATUS_EMPTY;
               end else begin
                  at_head = (req_action == dequ_pkg::ACT_POP_FRONT) != flip_ff;
                  mem_req.rd_en = 1'b1;
                  if (at_head) begin
                     mem_req.addr = head_ff;
                     head_in      = head_inc;
                  end else begin
                     mem_req.addr = last_pos;
                  end
                  count_in     = count_ff - dequ_pkg::CountWidth'(1);
                  // hold the result until the word comes back
                  rsp_valid_in = 1'b0;
                  state_in     = STATE_READ;
               end
            end
            dequ_pkg::ACT_REVERSE: begin
               flip_in = !flip_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         flip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         flip_ff      <= flip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pop_value  = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_count = rsp_count_ff;

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking bench for double_ended_queue_unit: a directed table, then push-heavy and
// pop-heavy random phases, checked against a ring-store predictor or the table's own results.
// Depends on dequ_pkg and the RTL under rtl/.

module testbench;

   localparam int PhaseLen   = 64;
   localparam int PhaseCount = 8;
   localparam int CycleLimit = 200000;
   localparam int DrainWait  = 8;
   localparam int DirRows    = 24;

   localparam logic [dequ_pkg::ActionWidth-1:0] ACT_UNUSED_5 = 3'd5;
   localparam logic [dequ_pkg::ActionWidth-1:0] ACT_UNUSED_6 = 3'd6;
   localparam logic [dequ_pkg::ActionWidth-1:0] ACT_UNUSED_7 = 3'd7;

   localparam logic [dequ_pkg::WordWidth-1:0] WORD_MAX  = 32'h7FFF_FFFF;
   localparam logic [dequ_pkg::WordWidth-1:0] WORD_MIN  = 32'h8000_0000;
   localparam logic [dequ_pkg::WordWidth-1:0] WORD_ONES = 32'hFFFF_FFFF;
   localparam logic [dequ_pkg::WordWidth-1:0] WORD_ZERO = 32'h0000_0000;

   typedef struct packed {
      logic [dequ_pkg::WordWidth-1:0]   pop_value;
      logic [dequ_pkg::StatusWidth-1:0] status;
      logic [dequ_pkg::CountWidth-1:0]  fill_count;
   } deque_result_type;

   typedef struct packed {
      logic [dequ_pkg::ActionWidth-1:0] action;
      logic [dequ_pkg::WordWidth-1:0]   value;
      logic                             has_result;
      deque_result_type                 result;
   } stim_row_type;

   logic                                  clock          = 1'b0;
   logic                                  reset          = 1'b1;
   logic                                  req_valid      = 1'b0;
   logic                                  req_ready;
   logic [dequ_pkg::ActionWidth-1:0]      req_action     = dequ_pkg::ACT_REVERSE;
   logic signed [dequ_pkg::WordWidth-1:0] req_push_value = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready      = 1'b0;
   logic signed [dequ_pkg::WordWidth-1:0] rsp_pop_value;
   logic [dequ_pkg::StatusWidth-1:0]      rsp_status;
   logic [dequ_pkg::CountWidth-1:0]       rsp_fill_count;

   // predictor state
   logic [dequ_pkg::WordWidth-1:0]  ring_words [dequ_pkg::Depth];
   logic [dequ_pkg::AddrWidth-1:0]  ring_head    = '0;
   logic [dequ_pkg::CountWidth-1:0] ring_count   = '0;
   logic                            ring_flipped = 1'b0;

   deque_result_type expected_results [$];
   int               fail_count    = 0;
   int               cycle_count   = 0;
   bit               steady_sender = 1'b0;

   // rows with has_result set carry their result; the rest go through the predictor
   stim_row_type dir_rows [DirRows] = '{
      '{dequ_pkg::ACT_POP_FRONT,  WORD_ZERO, 1'b1, '{WORD_ZERO, dequ_pkg::STATUS_EMPTY, 7'd0}},
      '{dequ_pkg::ACT_POP_BACK,   WORD_ONES, 1'b1, '{WORD_ZERO, dequ_pkg::STATUS_EMPTY, 7'd0}},
      '{dequ_pkg::ACT_REVERSE,    WORD_ZERO, 1'b1, '{WORD_ZERO, dequ_pkg::STATUS_OK,    7'd0}},
      '{dequ_pkg::ACT_REVERSE,    WORD_ONES, 1'b1, '{WORD_ZERO, dequ_pkg::STATUS_OK,    7'd0}},
      '{ACT_UNUSED_5,             WORD_ONES, 1'b1, '{WORD_ZERO, dequ_pkg::STATUS_OK,    7'd0}},
      '{ACT_UNUSED_6,             WORD_MAX,  1'b1, '{WORD_ZERO, dequ_pkg::STATUS_OK,    7'd0}},
      '{ACT_UNUSED_7,             WORD_MIN,  1'b1, '{WORD_ZERO, dequ_pkg::STATUS_OK,    7'd0}},
      '{dequ_pkg::ACT_PUSH_FRONT, WORD_MAX,  1'b1, '{WORD_ZERO, dequ_pkg::STATUS_OK,    7'd1}},
      '{dequ_pkg::ACT_PUSH_BACK,  WORD_MIN,  1'b1, '{WORD_ZERO, dequ_pkg::STATUS_OK,    7'd2}},
      '{dequ_pkg::ACT_PUSH_FRONT, WORD_ONES, 1'b1, '{WORD_ZERO, dequ_pkg::STATUS_OK,    7'd3}},
      '{dequ_pkg::ACT_PUSH_BACK,  WORD_ZERO, 1'b1, '{WORD_ZERO, dequ_pkg::STATUS_OK,    7'd4}},
      '{dequ_pkg::ACT_POP_FRONT,  WORD_ZERO, 1'b0, '0},
      '{dequ_pkg::ACT_REVERSE,    WORD_ZERO, 1'b0, '0},
      '{dequ_pkg::ACT_POP_FRONT,  WORD_ZERO, 1'b0, '0},
      '{dequ_pkg::ACT_PUSH_FRONT, 32'h5555_5555, 1'b0, '0},
      '{dequ_pkg::ACT_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, '0},
      '{dequ_pkg::ACT_POP_BACK,   WORD_ZERO, 1'b0, '0},
      '{ACT_UNUSED_5,             WORD_ZERO, 1'b0, '0},
      '{dequ_pkg::ACT_REVERSE,    WORD_ZERO, 1'b0, '0},
      '{dequ_pkg::ACT_POP_BACK,   WORD_ZERO, 1'b0, '0},
      '{dequ_pkg::ACT_POP_BACK,   WORD_ZERO, 1'b0, '0},
      '{dequ_pkg::ACT_POP_FRONT,  WORD_ZERO, 1'b0, '0},
      '{dequ_pkg::ACT_POP_FRONT,  WORD_ZERO, 1'b0, '0},
      '{dequ_pkg::ACT_POP_BACK,   WORD_ZERO, 1'b0, '0}
   };

   double_ended_queue_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count)
   );

   always #1 clock = ~clock;

   // Advance the deque by one request and return the result it must produce.
   function automatic deque_result_type apply_deque_action(
      logic [dequ_pkg::ActionWidth-1:0] action,
      logic [dequ_pkg::WordWidth-1:0]   value);
      deque_result_type               res;
      logic                           at_head;
      logic [dequ_pkg::AddrWidth-1:0] slot;
      res.pop_value = '0;
      res.status    = dequ_pkg::STATUS_OK;
      case (action)
         dequ_pkg::ACT_PUSH_FRONT, dequ_pkg::ACT_PUSH_BACK: begin
            if (ring_count >= dequ_pkg::CountWidth'(dequ_pkg::Depth)) begin
               res.status = dequ_pkg::STATUS_FULL;
            end else begin
               at_head = (action == dequ_pkg::ACT_PUSH_FRONT) != ring_flipped;
               if (at_head) begin
                  ring_head = ring_head - dequ_pkg::AddrWidth'(1);
                  ring_words[ring_head] = value;
               end else begin
                  slot = ring_head + dequ_pkg::AddrWidth'(ring_count);
                  ring_words[slot] = value;
               end
               ring_count = ring_count + dequ_pkg::CountWidth'(1);
            end
         end
         dequ_pkg::ACT_POP_FRONT, dequ_pkg::ACT_POP_BACK: begin
            if (ring_count == '0) begin
               res.status = dequ_pkg::STATUS_EMPTY;
            end else begin
               at_head = (action == dequ_pkg::ACT_POP_FRONT) != ring_flipped;
               if (at_head) begin
                  res.pop_value = ring_words[ring_head];
                  ring_head = ring_head + dequ_pkg::AddrWidth'(1);
               end else begin
                  slot = ring_head
                       + dequ_pkg::AddrWidth'(ring_count - dequ_pkg::CountWidth'(1));
                  res.pop_value = ring_words[slot];
               end
               ring_count = ring_count - dequ_pkg::CountWidth'(1);
            end
         end
         dequ_pkg::ACT_REVERSE: ring_flipped = ~ring_flipped;
         default: ;
      endcase
      res.fill_count = ring_count;
      return res;
   endfunction

   // Mostly back to back, sometimes a short gap, rarely a long pause.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Filling phases lean on pushes, draining phases on pops, so both ends get hit.
   function automatic logic [dequ_pkg::ActionWidth-1:0] pick_action(bit filling);
      int r;
      bit want_push;
      r = $urandom_range(0, 99);
      if (r < 6) return dequ_pkg::ACT_REVERSE;
      if (r < 10) return ACT_UNUSED_5 + dequ_pkg::ActionWidth'($urandom_range(0, 2));
      want_push = (r < 85) ? filling : !filling;
      if (want_push) begin
         return $urandom_range(0, 1) ? dequ_pkg::ACT_PUSH_FRONT : dequ_pkg::ACT_PUSH_BACK;
      end
      return $urandom_range(0, 1) ? dequ_pkg::ACT_POP_FRONT : dequ_pkg::ACT_POP_BACK;
   endfunction

   function automatic logic [dequ_pkg::WordWidth-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return WORD_ONES;
         3: return WORD_ZERO;
         default: return $urandom;
      endcase
   endfunction

   // Called right after a rising edge; returns at the edge that accepts the request.
   task automatic send_request(logic [dequ_pkg::ActionWidth-1:0] action,
                               logic [dequ_pkg::WordWidth-1:0] value,
                               logic has_result, deque_result_type given);
      int               gap;
      deque_result_type predicted;
      gap = steady_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_push_value <= value;
      do @(posedge clock); while (!req_ready);
      predicted = apply_deque_action(action, value);
      expected_results.push_back(has_result ? given : predicted);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i])
         send_request(dir_rows[i].action, dir_rows[i].value, dir_rows[i].has_result,
                      dir_rows[i].result);
      for (int p = 0; p < PhaseCount; p++) begin
         steady_sender = (p % 3 == 2);
         for (int n = 0; n < PhaseLen; n++)
            send_request(pick_action(p % 4 < 2), pick_word(), 1'b0, '0);
      end
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS double_ended_queue_unit");
      end else begin
         $display("FAIL double_ended_queue_unit");
      end
      $finish;
   end

   // Result side: hold ready for a run of cycles, then stall for a random gap.
   initial begin
      int hold;
      int gap;
      while (reset) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 100) : $urandom_range(1, 12);
         repeat (hold) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      deque_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with none expected: pop_value %0d status %0d fill_count %0d",
                     $time, rsp_pop_value, rsp_status, rsp_fill_count);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_pop_value !== want.pop_value) begin
               $display("%0t: pop_value expected %0d actual %0d", $time,
                        $signed(want.pop_value), rsp_pop_value);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               fail_count++;
            end
            if (rsp_fill_count !== want.fill_count) begin
               $display("%0t: fill_count expected %0d actual %0d", $time,
                        want.fill_count, rsp_fill_count);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
         $display("FAIL double_ended_queue_unit");
         $finish;
      end
   end

endmodule

/* filelist.f */
rtl/dequ_pkg.sv
rtl/dequ_ram.sv
rtl/dequ_ctrl.sv
rtl/double_ended_queue_unit.sv
sim/testbench.sv
